// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the chunked deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on the standard clk_i / rst_ni pair.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_STD(lbl, prop, msg)

`endif

`endif

// ----- rtl/hcd_pkg.sv -----
// Types, constants and helpers for the HTTP chunked deframer.
`default_nettype none

package hcd_pkg;

  // Default width of the chunk size counter.
  localparam int unsigned SIZE_BITS_DEF = 32;

  // Line control characters.
  localparam logic [7:0] CHR_CR   = 8'h0D;
  localparam logic [7:0] CHR_LF   = 8'h0A;
  localparam logic [7:0] CHR_SEMI = 8'h3B;

  // End kinds.
  localparam logic [1:0] END_NONE = 2'd0;
  localparam logic [1:0] END_DONE = 2'd1;
  localparam logic [1:0] END_ERR  = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_UNTERM = 2'd0;
  localparam logic [1:0] ERR_SIZE   = 2'd1;
  localparam logic [1:0] ERR_TRUNC  = 2'd2;
  localparam logic [1:0] ERR_TERM   = 2'd3;

  typedef enum logic [5:0] {
    PH_SIZE  = 6'b000001,
    PH_EXT   = 6'b000010,
    PH_DATA  = 6'b000100,
    PH_TCR   = 6'b001000,
    PH_TLF   = 6'b010000,
    PH_DRAIN = 6'b100000
  } hcd_phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } hcd_in_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload;
    logic [1:0] end_kind;
    logic [1:0] error_code;
  } hcd_out_t;

  // Parser control state (the size counter travels beside it).
  typedef struct packed {
    hcd_phase_e phase;
    logic       saw_digit;
    logic       size_bad;
    logic       cr_pending;
  } hcd_state_t;

  // Decode one hex digit: bit 4 set when the byte is a digit.
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hcd_step.sv -----
// Per-byte parser update: next state and the result of one item.
`default_nettype none

module hcd_step
  import hcd_pkg::*;
#(
  parameter int unsigned SizeBits = SIZE_BITS_DEF
) (
  input  hcd_in_t             item_i,
  input  hcd_state_t          state_i,
  input  logic [SizeBits-1:0] count_i,
  output hcd_state_t          state_o,
  output logic [SizeBits-1:0] count_o,
  output logic                res_vld_o,
  output hcd_out_t            res_o
);

  logic [7:0]          c;
  logic                last;
  logic [4:0]          hex;
  logic [SizeBits+3:0] wide;
  logic                fin;
  logic [1:0]          kind;
  logic [1:0]          code;
  logic                emit_data;

  assign c    = item_i.data_byte;
  assign last = item_i.last_byte;
  assign hex  = hex_decode(c);
  assign wide = {count_i, hex[3:0]};

  // Advance the parser by one byte
  always_comb begin
    state_o   = state_i;
    count_o   = count_i;
    fin       = 1'b0;
    kind      = END_NONE;
    code      = ERR_UNTERM;
    emit_data = 1'b0;

    unique case (state_i.phase)
      PH_SIZE, PH_EXT: begin
        if (state_i.cr_pending && c == CHR_LF) begin
          if (state_i.size_bad || !state_i.saw_digit) begin
            fin = 1'b1; kind = END_ERR; code = ERR_SIZE;
          end else if (count_i == '0) begin
            fin = 1'b1; kind = END_DONE; code = ERR_UNTERM;
          end else if (last) begin
            fin = 1'b1; kind = END_ERR; code = ERR_TRUNC;
          end else begin
            state_o.cr_pending = 1'b0;
            state_o.phase      = PH_DATA;
          end
        end else begin
          if (state_i.phase == PH_SIZE) begin
            // A CR not followed by LF spoils the size
            if (state_i.cr_pending) state_o.size_bad = 1'b1;
            state_o.cr_pending = 1'b0;
            if (c == CHR_CR) begin
              state_o.cr_pending = 1'b1;
            end else if (c == CHR_SEMI) begin
              state_o.phase = PH_EXT;
            end else if (!hex[4]) begin
              state_o.size_bad = 1'b1;
            end else begin
              state_o.saw_digit = 1'b1;
              if (!state_o.size_bad) begin
                if (count_i[SizeBits-1 -: 4] != 4'd0) begin
                  state_o.size_bad = 1'b1;
                end else begin
                  count_o = wide[SizeBits-1:0];
                end
              end
            end
          end else begin
            state_o.cr_pending = (c == CHR_CR);
          end
          if (last) begin
            fin = 1'b1; kind = END_ERR; code = ERR_UNTERM;
          end
        end
      end
      PH_DATA: begin
        if (last) begin
          fin = 1'b1; kind = END_ERR; code = ERR_TRUNC;
        end else begin
          count_o   = count_i - SizeBits'(1);
          emit_data = 1'b1;
          if (count_i == SizeBits'(1)) state_o.phase = PH_TCR;
        end
      end
      PH_TCR: begin
        if (last) begin
          fin = 1'b1; kind = END_ERR; code = ERR_TRUNC;
        end else if (c != CHR_CR) begin
          fin = 1'b1; kind = END_ERR; code = ERR_TERM;
        end else begin
          state_o.phase = PH_TLF;
        end
      end
      PH_TLF: begin
        if (c != CHR_LF) begin
          fin = 1'b1; kind = END_ERR; code = ERR_TERM;
        end else if (last) begin
          fin = 1'b1; kind = END_ERR; code = ERR_UNTERM;
        end else begin
          state_o.phase      = PH_SIZE;
          state_o.saw_digit  = 1'b0;
          state_o.size_bad   = 1'b0;
          state_o.cr_pending = 1'b0;
          count_o            = '0;
        end
      end
      PH_DRAIN: begin
        if (last) begin
          state_o.phase      = PH_SIZE;
          state_o.saw_digit  = 1'b0;
          state_o.size_bad   = 1'b0;
          state_o.cr_pending = 1'b0;
          count_o            = '0;
        end
      end
      default: begin
        state_o.phase      = PH_SIZE;
        state_o.saw_digit  = 1'b0;
        state_o.size_bad   = 1'b0;
        state_o.cr_pending = 1'b0;
        count_o            = '0;
      end
    endcase

    // Finish the body: restart on the last byte, otherwise drain
    if (fin) begin
      if (last) begin
        state_o.phase      = PH_SIZE;
        state_o.saw_digit  = 1'b0;
        state_o.size_bad   = 1'b0;
        state_o.cr_pending = 1'b0;
        count_o            = '0;
      end else begin
        state_o.phase = PH_DRAIN;
      end
    end
  end

  // Build the result item
  always_comb begin
    res_vld_o           = fin || emit_data;
    res_o.payload_valid = emit_data;
    res_o.payload       = emit_data ? c : 8'd0;
    res_o.end_kind      = fin ? kind : END_NONE;
    res_o.error_code    = (fin && kind == END_ERR) ? code : ERR_UNTERM;
  end

endmodule

`default_nettype wire

// ----- rtl/http_chunked_deframer.sv -----
// Top level of the HTTP/1.1 chunked body deframer.
// A transferred byte lands in the input register; its result then loads into the result register once that can take it.
// Throughput: one byte per cycle; ready drops only while a result waits on a stall.
// Rate is set by the combinational parser update between input and result registers.
// Reset: rst_ni low clears both valid flags and returns the parser to the size line.
`default_nettype none

`include "assert_macros.svh"

module http_chunked_deframer
  import hcd_pkg::*;
#(
  parameter int unsigned SizeBits = SIZE_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  hcd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output hcd_out_t out_data_o
);

  logic                in_vld_q;
  hcd_in_t             in_item_q;
  hcd_state_t          state_q, state_d;
  logic [SizeBits-1:0] count_q, count_d;
  logic                out_vld_q;
  hcd_out_t            out_item_q;
  logic                res_vld;
  hcd_out_t            res;
  logic                advance;

  // Process the held byte when the result register can take a new value
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  hcd_step #(
    .SizeBits(SizeBits)
  ) u_step (
    .item_i    (in_item_q),
    .state_i   (state_q),
    .count_i   (count_q),
    .state_o   (state_d),
    .count_o   (count_d),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_item_q <= in_data_i;
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase      <= PH_SIZE;
      state_q.saw_digit  <= 1'b0;
      state_q.size_bad   <= 1'b0;
      state_q.cr_pending <= 1'b0;
      count_q            <= '0;
    end else if (advance) begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Result register: hold under stall, load on a new result, clear once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res_vld;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_vld) out_item_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_item_q;

  `ASSERT_STD(a_in_lands, in_valid_i && in_ready_o |=> in_vld_q,
              "accepted transfer missing from input register")
  `ASSERT_STD(a_res_loaded, advance && res_vld |=> out_valid_o,
              "result not loaded into output register")
  `ASSERT_STD(a_out_kept, out_valid_o && !out_ready_i |=> out_valid_o,
              "stalled result dropped")
  `ASSERT_STD(a_data_count, state_q.phase == PH_DATA |-> count_q != '0,
              "data phase with zero remaining count")

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Testbench for the HTTP chunked body deframer: directed and random chunked bodies checked by a byte decoder.
module tb;
  import hcd_pkg::*;

  localparam int unsigned SB = SIZE_BITS_DEF;

  typedef struct packed {
    hcd_in_t beat;
    logic    wait_empty;
  } tx_item_t;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  hcd_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  hcd_out_t out_data_o;

  http_chunked_deframer #(
    .SizeBits(SB)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  tx_item_t    pend_q[$];
  hcd_out_t    exp_q[$];
  logic [7:0]  msg[$];
  int unsigned rand_items = 0;
  int unsigned errors = 0;
  bit          in_taken = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned rx_stall = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  // Decoder state
  hcd_phase_e  prs_phase;
  logic [SB-1:0] size_acc;
  logic        saw_hex;
  logic        size_err;
  logic        cr_seen;

  function automatic void clear_size_line();
    size_acc = '0;
    saw_hex  = 1'b0;
    size_err = 1'b0;
    cr_seen  = 1'b0;
  endfunction

  function automatic void restart_parse();
    prs_phase = PH_SIZE;
    clear_size_line();
  endfunction

  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'h0;
    if (c >= "0" && c <= "9") v = 4'(c - "0");
    else if (c >= "a" && c <= "f") v = 4'(c - "a" + 10);
    else if (c >= "A" && c <= "F") v = 4'(c - "A" + 10);
    else return 1'b0;
    return 1'b1;
  endfunction

  // Advance the decoder by one byte; return 1 when the byte yields a result.
  function automatic bit deframe_step(input hcd_in_t b, output hcd_out_t r);
    logic [7:0] c;
    logic       lst;
    logic [3:0] nib;
    bit         ends;
    bit         has;
    logic [1:0] kind;
    logic [1:0] code;
    c    = b.data_byte;
    lst  = b.last_byte;
    ends = 1'b0;
    has  = 1'b0;
    kind = END_NONE;
    code = ERR_UNTERM;
    r    = '0;
    case (prs_phase)
      PH_SIZE, PH_EXT: begin
        if (cr_seen && c == CHR_LF) begin
          if (size_err || !saw_hex) begin
            ends = 1'b1;
            kind = END_ERR;
            code = ERR_SIZE;
          end else if (size_acc == '0) begin
            ends = 1'b1;
            kind = END_DONE;
          end else if (lst) begin
            ends = 1'b1;
            kind = END_ERR;
            code = ERR_TRUNC;
          end else begin
            cr_seen   = 1'b0;
            prs_phase = PH_DATA;
          end
        end else begin
          if (prs_phase == PH_SIZE) begin
            // a CR not followed by LF spoils the size
            if (cr_seen) size_err = 1'b1;
            cr_seen = 1'b0;
            if (c == CHR_CR) begin
              cr_seen = 1'b1;
            end else if (c == CHR_SEMI) begin
              prs_phase = PH_EXT;
            end else if (!hex_nibble(c, nib)) begin
              size_err = 1'b1;
            end else begin
              saw_hex = 1'b1;
              if (!size_err) begin
                if (size_acc[SB-1 -: 4] != 4'h0) size_err = 1'b1;
                else size_acc = {size_acc[SB-5:0], nib};
              end
            end
          end else begin
            cr_seen = (c == CHR_CR);
          end
          if (lst) begin
            ends = 1'b1;
            kind = END_ERR;
            code = ERR_UNTERM;
          end
        end
      end
      PH_DATA: begin
        if (lst) begin
          ends = 1'b1;
          kind = END_ERR;
          code = ERR_TRUNC;
        end else begin
          size_acc = size_acc - 1'b1;
          if (size_acc == '0) prs_phase = PH_TCR;
          r.payload_valid = 1'b1;
          r.payload       = c;
          has             = 1'b1;
        end
      end
      PH_TCR: begin
        if (lst || c != CHR_CR) begin
          ends = 1'b1;
          kind = END_ERR;
          code = lst ? ERR_TRUNC : ERR_TERM;
        end else begin
          prs_phase = PH_TLF;
        end
      end
      PH_TLF: begin
        if (c != CHR_LF || lst) begin
          ends = 1'b1;
          kind = END_ERR;
          code = (c != CHR_LF) ? ERR_TERM : ERR_UNTERM;
        end else begin
          prs_phase = PH_SIZE;
          clear_size_line();
        end
      end
      default: begin
        if (lst) restart_parse();
      end
    endcase
    if (ends) begin
      r.end_kind = kind;
      if (kind == END_ERR) r.error_code = code;
      has = 1'b1;
      if (lst) restart_parse();
      else prs_phase = PH_DRAIN;
    end
    return has;
  endfunction

  // Mostly short gaps, a few long ones, none in calm stretches.
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] hex_char(input int unsigned v);
    if (v < 10) return 8'(8'h30 + v);
    return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
  endfunction

  function automatic logic [7:0] pick_bad();
    case ($urandom_range(0, 3))
      0: return CHR_CR;
      1: return CHR_LF;
      2: return "g";
      default: return 8'($urandom);
    endcase
  endfunction

  // Append one byte to the message being built.
  task automatic put_byte(input logic [7:0] b);
    msg = {msg, b};
  endtask

  task automatic add_crlf();
    put_byte(CHR_CR);
    put_byte(CHR_LF);
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) put_byte(s[i]);
  endtask

  // Extension bytes; a CR inside is kept bare so it never closes the line.
  task automatic add_ext();
    logic [7:0] b;
    put_byte(CHR_SEMI);
    repeat ($urandom_range(0, 4)) begin
      b = 8'($urandom);
      put_byte(b);
      if (b == CHR_CR) put_byte(8'h20);
    end
  endtask

  task automatic add_size_line(input logic [31:0] sz);
    int unsigned nd;
    nd = 1;
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 2)) put_byte("0");
    while (nd < 8 && (sz >> (4 * nd)) != 0) nd++;
    for (int i = nd - 1; i >= 0; i--) put_byte(hex_char((sz >> (4 * i)) & 32'hF));
    if ($urandom_range(0, 3) == 0) add_ext();
    add_crlf();
  endtask

  task automatic add_good_body();
    int unsigned sz;
    repeat ($urandom_range(0, 4)) begin
      sz = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
      add_size_line(sz);
      repeat (sz) put_byte(8'($urandom));
      add_crlf();
    end
    add_size_line(0);
    repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
  endtask

  // Queue the message, flagging its final byte as last.
  task automatic commit_msg(input bit hold, input bit counted);
    tx_item_t it;
    for (int i = 0; i < msg.size(); i++) begin
      it.beat.data_byte = msg[i];
      it.beat.last_byte = (i == msg.size() - 1);
      it.wait_empty     = hold && (i == 0);
      pend_q = {pend_q, it};
    end
    if (counted) rand_items += msg.size();
    msg.delete();
  endtask

  task automatic add_broken_body();
    int unsigned k;
    case ($urandom_range(0, 5))
      0: begin
        // cut the body short anywhere
        add_good_body();
        k = $urandom_range(1, msg.size());
        while (msg.size() > k) void'(msg.pop_back());
      end
      1: begin
        add_good_body();
        msg[$urandom_range(0, msg.size() - 1)] = pick_bad();
      end
      2: begin
        // size too wide for the counter
        put_byte(hex_char($urandom_range(1, 15)));
        repeat ($urandom_range(8, 10)) put_byte(hex_char($urandom_range(0, 15)));
        add_crlf();
        repeat (2) put_byte(8'($urandom));
      end
      3: begin
        if ($urandom_range(0, 1)) add_ext();
        add_crlf();
        repeat (2) put_byte(8'($urandom));
      end
      4: begin
        repeat ($urandom_range(1, 8)) put_byte(8'($urandom));
      end
      default: begin
        // widest size that still fits, then truncate
        put_byte(hex_char($urandom_range(8, 15)));
        repeat (7) put_byte(hex_char($urandom_range(0, 15)));
        add_crlf();
        repeat ($urandom_range(1, 5)) put_byte(8'($urandom));
      end
    endcase
  endtask

  task automatic check_field(input string fname, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 40) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
      end
    end
  endtask

  // Sample both transfers at the rising edge; check results, then predict.
  always @(posedge clk_i) begin
    hcd_out_t want;
    hcd_out_t got;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = out_data_o;
        if (exp_q.size() == 0) begin
          errors++;
          if (errors <= 40) begin
            $display("%0t: unexpected result: expected none, actual %h", $time, got);
          end
        end else begin
          want = exp_q.pop_front();
          check_field("payload_valid", want.payload_valid, got.payload_valid);
          check_field("payload", want.payload, got.payload);
          check_field("end_kind", want.end_kind, got.end_kind);
          check_field("error_code", want.error_code, got.error_code);
        end
      end
      if (in_valid_i && in_ready_o) begin
        in_taken = 1'b1;
        if (deframe_step(in_data_i, want)) exp_q = {exp_q, want};
      end
    end
  end

  // Drive the next byte at the falling edge once the previous one is transferred.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (tx_gap != 0) begin
        in_valid_i <= 1'b0;
        tx_gap--;
      end else if (pend_q.size() != 0 && !(pend_q[0].wait_empty && exp_q.size() != 0)) begin
        in_data_i  <= pend_q[0].beat;
        in_valid_i <= 1'b1;
        void'(pend_q.pop_front());
        tx_gap = pick_gap(tx_calm);
        if ($urandom_range(0, 149) == 0) tx_calm = !tx_calm;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Stall the result side at random.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_stall != 0) begin
        out_ready_i <= 1'b0;
        rx_stall--;
      end else begin
        out_ready_i <= 1'b1;
        rx_stall = pick_gap(rx_calm);
      end
      if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    restart_parse();

    // extension, top data byte, done on the last byte
    add_text("1;");
    add_crlf();
    put_byte(8'hFF);
    add_crlf();
    add_text("0");
    add_crlf();
    commit_msg(1'b0, 1'b0);
    // zero byte and bare LF, line never ended
    put_byte(8'h00);
    put_byte(CHR_LF);
    commit_msg(1'b0, 1'b0);
    // bare CR then CR LF: bad size
    put_byte(CHR_CR);
    add_crlf();
    commit_msg(1'b0, 1'b0);
    // nonzero size line closed by the last byte
    add_text("a");
    add_crlf();
    commit_msg(1'b0, 1'b0);
    // wrong byte where LF is due
    add_text("1");
    add_crlf();
    add_text("Q");
    put_byte(CHR_CR);
    add_text("X");
    commit_msg(1'b0, 1'b0);

    // random bodies, mostly well formed
    begin
      bit first;
      first = 1'b1;
      while (rand_items < 750) begin
        if ($urandom_range(0, 9) < 7) add_good_body();
        else add_broken_body();
        commit_msg(first || $urandom_range(0, 9) == 0, 1'b1);
        first = 1'b0;
      end
    end

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pend_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/hcd_pkg.sv
rtl/hcd_step.sv
rtl/http_chunked_deframer.sv
tb/sv/tb.sv
